// ===== hdl/pda_pkg.sv =====
// Shared types, constants and fixed-point helpers of the path distance accumulator.
package pda_pkg;

  localparam int DEF_MAX_VEHICLES = 16;
  localparam int DEF_CORDIC_STEPS = 24;

  typedef logic signed [33:0] fix_t;
  typedef logic signed [34:0] angle_t;

  localparam angle_t FULL_TURN    = 35'sd7200000000;
  localparam angle_t HALF_TURN    = 35'sd3600000000;
  localparam angle_t QUARTER_TURN = 35'sd1800000000;
  localparam fix_t   DEG_TO_RAD   = 34'sd4024455250;
  localparam fix_t   INV_GAIN     = 34'sd652032874;
  localparam fix_t   ONE_Q30      = 34'sd1073741824;
  localparam fix_t   PLANET_RADIUS_M = 34'sd6371000;
  localparam int     UNSET_BAND   = 100;
  localparam logic [47:0] SAT48   = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] UNIT_METERS      = 3'd0;
  localparam logic [2:0] UNIT_FEET        = 3'd1;
  localparam logic [2:0] UNIT_YARDS       = 3'd2;
  localparam logic [2:0] UNIT_MILES       = 3'd3;
  localparam logic [2:0] UNIT_KILOMETERS  = 3'd4;
  localparam logic [2:0] UNIT_ATTOPARSECS = 3'd5;

  localparam logic ADDR_DISTANCE_UNITS = 1'b0;

  typedef struct packed {
    logic [3:0]  id;
    logic [30:0] lat;
    logic [31:0] lon;
    logic        in_range;
  } pda_item_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } cordic_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_ANGLE, ST_ANGLE_MUL, ST_ROTATE, ST_SAVE,
    ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_ROOT, ST_VECTOR,
    ST_SEG, ST_SEG_MUL, ST_UPDATE, ST_CONVERT, ST_DONE
  } pda_state_t;

  function automatic fix_t arc_entry(input logic [4:0] i);
    fix_t v;
    unique case (i)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      5'd30: v = 34'sh00000001;
      5'd31: v = 34'sh00000000;
    endcase
    return v;
  endfunction

  function automatic logic [37:0] unit_factor(input logic [2:0] u);
    logic [37:0] f;
    unique case (u)
      UNIT_FEET:        f = 38'd14091100052;
      UNIT_YARDS:       f = 38'd4697033351;
      UNIT_MILES:       f = 38'd2668769;
      UNIT_KILOMETERS:  f = 38'd4294967;
      UNIT_ATTOPARSECS: f = 38'd139190290382;
      default:          f = 38'd4294967296;
    endcase
    return f;
  endfunction

  // One CORDIC micro-rotation; in vectoring mode the direction follows the sign of y.
  function automatic cordic_t cordic_step(input fix_t x, input fix_t y, input fix_t z,
                                          input logic [4:0] i, input logic vect);
    cordic_t r;
    fix_t dx;
    fix_t dy;
    logic pos;
    dx = y >>> i;
    dy = x >>> i;
    pos = vect ? (y < 0) : (z >= 0);
    if (pos) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - arc_entry(i);
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + arc_entry(i);
    end
    return r;
  endfunction

endpackage

// ===== hdl/pda_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pda_front.sv =====
// Front end: accepts position fixes, classifies the vehicle number and queues them.
module pda_front #(
  parameter int MAX_VEHICLES = pda_pkg::DEF_MAX_VEHICLES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          vehicle_id,
  input  logic signed [30:0]  latitude,
  input  logic signed [31:0]  longitude,
  output logic                q_valid,
  output pda_pkg::pda_item_t  q_item,
  input  logic                q_pop
);
  import pda_pkg::*;

  pda_item_t entries [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;
  logic       push;
  pda_item_t  item_in;

  always_comb begin
    item_in.id       = vehicle_id;
    item_in.lat      = latitude;
    item_in.lon      = longitude;
    item_in.in_range = {5'd0, vehicle_id} < 9'(MAX_VEHICLES);
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item_in;
    end
  end

endmodule

// ===== hdl/pda_engine.sv =====
// Back end: per-vehicle state, haversine sequencer and unit conversion.
module pda_engine #(
  parameter int MAX_VEHICLES = pda_pkg::DEF_MAX_VEHICLES,
  parameter int CORDIC_STEPS = pda_pkg::DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pda_pkg::pda_item_t q_item,
  output logic               q_pop,
  input  logic [2:0]         distance_units,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         vehicle_out,
  output logic [47:0]        vehicle_path,
  output logic [47:0]        total_path,
  output logic               segment_added
);
  import pda_pkg::*;

  localparam int IDW = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam int RW  = 31 + 32 + 48;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] LAST_ROOT = 5'd31;
  localparam logic [4:0] LAST_CONV = 5'd4;

  pda_state_t state, state_next;
  pda_item_t  item;
  logic [1:0] k;
  logic [4:0] cnt;
  logic [IDW-1:0] idx;
  logic [MAX_VEHICLES-1:0] vld;
  logic vld_rd;

  logic signed [30:0] last_lat;
  logic signed [31:0] last_lon;
  logic [47:0] vm, vm_next, total, total_next;
  logic [47:0] d;
  logic added;

  fix_t sdl, sdn, cl1, cl2, tmp, cx, cy, cz;
  logic neg_z, neg_cos;
  logic [63:0] v_a, v_b, r_a, r_b, bitm;

  logic ram_we, ram_re;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic signed [30:0] rd_lat;
  logic signed [31:0] rd_lon;
  logic [47:0] rd_vm;
  logic rd_set;

  fix_t mul_a, mul_b;
  logic signed [67:0] prod;
  fix_t prod_q30;
  logic [23:0] umul_a;
  logic [61:0] uprod, pp;
  logic [47:0] path_res, total_res;

  angle_t ang, r1, r2, amag;
  logic fold_neg;
  cordic_t cstep;
  fix_t th, zp;
  logic signed [34:0] asum;
  logic [30:0] a_cl;
  logic [63:0] sum_a, sum_b, va_n, vb_n, ra_n, rb_n;
  logic ge_a, ge_b;
  logic [67:0] seg_sum;
  logic [48:0] vm_sum, tot_sum;
  logic load_out;

  function automatic logic [47:0] conv(input logic [61:0] p, input logic [61:0] q);
    logic [63:0] lo;
    logic [63:0] r;
    lo = (64'(p[7:0]) << 24) + 64'(q) + 64'h8000_0000;
    r = 64'(p >> 8) + (lo >> 32);
    return (r > 64'(SAT48)) ? SAT48 : r[47:0];
  endfunction

  assign idx = IDW'(item.id);

  pda_ram #(.WIDTH(RW), .DEPTH(MAX_VEHICLES)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (IDW'(q_item.id)),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_lat = vld_rd ? $signed(ram_rdata[110:80]) : 31'sd0;
    rd_lon = vld_rd ? $signed(ram_rdata[79:48]) : 32'sd0;
    rd_vm  = vld_rd ? ram_rdata[47:0] : 48'd0;
    rd_set = (rd_lat > 31'(UNSET_BAND) || rd_lat < -31'(UNSET_BAND)) &&
             (rd_lon > 32'(UNSET_BAND) || rd_lon < -32'(UNSET_BAND));
  end

  always_comb begin
    unique case (k)
      2'd0: ang = 35'(last_lat) - 35'($signed(item.lat));
      2'd1: ang = 35'(last_lon) - 35'($signed(item.lon));
      2'd2: ang = 35'($signed(item.lat)) <<< 1;
      2'd3: ang = 35'(last_lat) <<< 1;
    endcase
    if (ang > HALF_TURN) begin
      r1 = ang - FULL_TURN;
    end else if (ang <= -HALF_TURN) begin
      r1 = ang + FULL_TURN;
    end else begin
      r1 = ang;
    end
    fold_neg = 1'b0;
    if (r1 > QUARTER_TURN) begin
      r2 = (QUARTER_TURN <<< 1) - r1;
      fold_neg = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2 = -(QUARTER_TURN <<< 1) - r1;
      fold_neg = 1'b1;
    end else begin
      r2 = r1;
    end
    amag = (r2 < 0) ? -r2 : r2;
  end

  always_comb begin
    cstep    = cordic_step(cx, cy, cz, cnt, state == ST_VECTOR);
    prod_q30 = prod[63:30];
    zp       = $signed({2'b00, prod[63:32]});
    th       = (cz < 0) ? 34'sd0 : cz;
    asum     = 35'(prod_q30) + 35'(tmp);
    if (asum < 0) begin
      a_cl = 31'd0;
    end else if (asum > 35'(ONE_Q30)) begin
      a_cl = 31'(ONE_Q30);
    end else begin
      a_cl = asum[30:0];
    end
    sum_a = r_a + bitm;
    sum_b = r_b + bitm;
    ge_a  = v_a >= sum_a;
    ge_b  = v_b >= sum_b;
    va_n  = ge_a ? v_a - sum_a : v_a;
    vb_n  = ge_b ? v_b - sum_b : v_b;
    ra_n  = ge_a ? (r_a >> 1) + bitm : r_a >> 1;
    rb_n  = ge_b ? (r_b >> 1) + bitm : r_b >> 1;
    seg_sum = prod + 68'sd524288;
    vm_sum  = 49'(vm) + 49'(d);
    tot_sum = 49'(total) + 49'(d);
    vm_next    = vm;
    total_next = total;
    if (added) begin
      vm_next    = (vm_sum > 49'(SAT48)) ? SAT48 : vm_sum[47:0];
      total_next = (tot_sum > 49'(SAT48)) ? SAT48 : tot_sum[47:0];
    end
    ram_wdata = {item.lat, item.lon, vm_next};
    load_out  = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (q_valid) state_next = ST_READ;
      ST_READ: begin
        if (!item.in_range) begin
          state_next = ST_CONVERT;
        end else if (rd_set) begin
          state_next = ST_ANGLE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_ANGLE:     state_next = ST_ANGLE_MUL;
      ST_ANGLE_MUL: state_next = ST_ROTATE;
      ST_ROTATE:    if (cnt == LAST_STEP) state_next = ST_SAVE;
      ST_SAVE:      state_next = (k == 2'd3) ? ST_MUL1 : ST_ANGLE;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_MUL3;
      ST_MUL3:      state_next = ST_MUL4;
      ST_MUL4:      state_next = ST_MUL5;
      ST_MUL5:      state_next = ST_ROOT;
      ST_ROOT:      if (cnt == LAST_ROOT) state_next = ST_VECTOR;
      ST_VECTOR:    if (cnt == LAST_STEP) state_next = ST_SEG;
      ST_SEG:       state_next = ST_SEG_MUL;
      ST_SEG_MUL:   state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_CONVERT;
      ST_CONVERT:   if (cnt == LAST_CONV) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == ST_IDLE) && q_valid;
    ram_re = q_pop;
    ram_we = (state == ST_UPDATE);
    mul_a  = 34'sd0;
    mul_b  = 34'sd0;
    unique case (state)
      ST_ANGLE: begin
        mul_a = 34'(amag);
        mul_b = DEG_TO_RAD;
      end
      ST_MUL1: begin
        mul_a = cl1;
        mul_b = cl2;
      end
      ST_MUL2: begin
        mul_a = sdn;
        mul_b = sdn;
      end
      ST_MUL3: begin
        mul_a = tmp;
        mul_b = prod_q30;
      end
      ST_MUL4: begin
        mul_a = sdl;
        mul_b = sdl;
      end
      ST_SEG: begin
        mul_a = th <<< 1;
        mul_b = PLANET_RADIUS_M;
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
      end
    endcase
    unique case (cnt[1:0])
      2'd0:    umul_a = vm[47:24];
      2'd1:    umul_a = vm[23:0];
      2'd2:    umul_a = total[47:24];
      default: umul_a = total[23:0];
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    uprod <= 62'(umul_a) * 62'(unit_factor(distance_units));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 5'd0;
      k         <= 2'd0;
      vld       <= '0;
      total     <= 48'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 5'd0 : cnt + 5'd1;
      if (state == ST_READ) begin
        k <= 2'd0;
      end else if (state == ST_SAVE) begin
        k <= k + 2'd1;
      end
      if (ram_we) begin
        vld[idx] <= 1'b1;
        total    <= total_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item   <= q_item;
      vld_rd <= vld[IDW'(q_item.id)];
    end
    unique case (state)
      ST_READ: begin
        last_lat <= rd_lat;
        last_lon <= rd_lon;
        vm       <= item.in_range ? rd_vm : 48'd0;
        added    <= item.in_range && rd_set;
        d        <= 48'd0;
      end
      ST_ANGLE: begin
        neg_z   <= r2 < 0;
        neg_cos <= fold_neg;
      end
      ST_ANGLE_MUL: begin
        cx <= INV_GAIN;
        cy <= 34'sd0;
        cz <= neg_z ? -zp : zp;
      end
      ST_ROTATE, ST_VECTOR: begin
        cx <= cstep.x;
        cy <= cstep.y;
        cz <= cstep.z;
      end
      ST_SAVE: begin
        unique case (k)
          2'd0: sdl <= cy;
          2'd1: sdn <= cy;
          2'd2: cl1 <= neg_cos ? -cx : cx;
          2'd3: cl2 <= neg_cos ? -cx : cx;
        endcase
      end
      ST_MUL2: tmp <= prod_q30;
      ST_MUL4: tmp <= prod_q30;
      ST_MUL5: begin
        v_a  <= 64'(a_cl) << 30;
        v_b  <= 64'(31'(ONE_Q30) - a_cl) << 30;
        r_a  <= 64'd0;
        r_b  <= 64'd0;
        bitm <= 64'd1 << 62;
      end
      ST_ROOT: begin
        v_a  <= va_n;
        v_b  <= vb_n;
        r_a  <= ra_n;
        r_b  <= rb_n;
        bitm <= bitm >> 2;
        if (cnt == LAST_ROOT) begin
          cx <= 34'(rb_n);
          cy <= 34'(ra_n);
          cz <= 34'sd0;
        end
      end
      ST_SEG_MUL: d <= seg_sum[67:20];
      ST_UPDATE:  vm <= vm_next;
      ST_CONVERT: begin
        if (cnt == 5'd1 || cnt == 5'd3) begin
          pp <= uprod;
        end
        if (cnt == 5'd2) begin
          path_res <= item.in_range ? conv(pp, uprod) : 48'd0;
        end
        if (cnt == LAST_CONV) begin
          total_res <= conv(pp, uprod);
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      vehicle_out   <= item.id;
      vehicle_path  <= path_res;
      total_path    <= total_res;
      segment_added <= added;
    end
  end

endmodule

// ===== hdl/path_distance_accumulator.sv =====
// Each fix runs through the shared CORDIC, multiplier and root sequencer, and fixes with no segment
// skip the haversine steps; the engine takes the next fix from the queue only once the last is done.
// A two-deep queue takes fixes while the engine works; the output register holds one result.
// Synchronous reset clears the queue, all vehicle paths, the total and the unit register.
// Per-vehicle state lives in RAM with reset-cleared valid bits, so no clearing pass is needed.
module path_distance_accumulator #(
  parameter int MAX_VEHICLES = pda_pkg::DEF_MAX_VEHICLES,
  parameter int CORDIC_STEPS = pda_pkg::DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         vehicle_id,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         vehicle_out,
  output logic [47:0]        vehicle_path,
  output logic [47:0]        total_path,
  output logic               segment_added
);
  import pda_pkg::*;

  logic [2:0] distance_units;
  logic       q_valid;
  logic       q_pop;
  pda_item_t  q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_DISTANCE_UNITS) ? {29'd0, distance_units} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_units <= UNIT_METERS;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ADDR_DISTANCE_UNITS) begin
      distance_units <= pwdata[2:0];
    end
  end

  pda_front #(.MAX_VEHICLES(MAX_VEHICLES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vehicle_id (vehicle_id),
    .latitude   (latitude),
    .longitude  (longitude),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  pda_engine #(.MAX_VEHICLES(MAX_VEHICLES), .CORDIC_STEPS(CORDIC_STEPS)) u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .distance_units (distance_units),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vehicle_out    (vehicle_out),
    .vehicle_path   (vehicle_path),
    .total_path     (total_path),
    .segment_added  (segment_added)
  );

endmodule

// ===== hdl/pda_checker.sv =====
// Port-level assertions for the path distance accumulator, bound to the top level.
module pda_checker #(
  parameter int MAX_VEHICLES = pda_pkg::DEF_MAX_VEHICLES
) (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  vehicle_out,
  input logic [47:0] vehicle_path,
  input logic [47:0] total_path,
  input logic        segment_added
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vehicle_out) &&
    $stable(vehicle_path) && $stable(total_path) && $stable(segment_added))
    else $error("stalled result changed");

  // An unknown vehicle number adds nothing and reports no path.
  a_unknown_vehicle: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({5'd0, vehicle_out} >= 9'(MAX_VEHICLES)) |->
    vehicle_path == 48'd0 && !segment_added)
    else $error("unknown vehicle reported a path");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the queue, so the input side is free straight away.
  a_reset_queue: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind path_distance_accumulator pda_checker #(.MAX_VEHICLES(MAX_VEHICLES)) u_pda_checker (.*);
